>>> design/slfc_pkg.sv
// ----------------------------------------------------------------------------
// slfc_pkg : segment LCD frame composer package
// Store size, command codes, segment code tables and icon map.
// ----------------------------------------------------------------------------
package slfc_pkg;

  localparam int STORE_BYTES = 20;
  localparam int FRAME_LEN   = 19;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int IDXW        = 5;

  typedef logic [2:0]    cmd_t;
  typedef logic [7:0]    byte_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [IDXW-1:0] idx_t;

  localparam cmd_t CMD_CLEAR    = 3'd0;
  localparam cmd_t CMD_DIGIT    = 3'd1;
  localparam cmd_t CMD_ICON_ON  = 3'd2;
  localparam cmd_t CMD_ICON_OFF = 3'd3;
  localparam cmd_t CMD_COMMIT   = 3'd4;

  localparam byte_t KEEP_DP   = 8'h80;
  localparam byte_t KEEP_LO   = 8'h0f;
  localparam byte_t KEEP_HI5  = 8'hf8;
  localparam byte_t KEEP_ALL  = 8'hff;

  localparam int ICON_COUNT = 6;

  // Row one 7-segment codes
  function automatic logic [6:0] row1_code(input logic [4:0] sym);
    logic [6:0] c;
    case (sym)
      5'd0:  c = 7'h5f;  5'd1:  c = 7'h50;  5'd2:  c = 7'h3d;  5'd3:  c = 7'h79;
      5'd4:  c = 7'h72;  5'd5:  c = 7'h6b;  5'd6:  c = 7'h6f;  5'd7:  c = 7'h51;
      5'd8:  c = 7'h7f;  5'd9:  c = 7'h7b;  5'd10: c = 7'h77;  5'd11: c = 7'h6e;
      5'd12: c = 7'h0f;  5'd13: c = 7'h7c;  5'd14: c = 7'h2f;  5'd15: c = 7'h27;
      5'd16: c = 7'h76;  5'd17: c = 7'h0e;  5'd18: c = 7'h24;  5'd19: c = 7'h37;
      5'd20: c = 7'h57;  5'd21: c = 7'h20;  5'd22: c = 7'h01;  5'd23: c = 7'h08;
      5'd24: c = 7'h33;  5'd25: c = 7'h6c;  5'd26: c = 7'h5e;  5'd27: c = 7'h2c;
      5'd28: c = 7'h3b;  5'd29: c = 7'h6d;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Rows two and three 7-segment codes
  function automatic logic [6:0] row23_code(input logic [4:0] sym);
    logic [6:0] c;
    case (sym)
      5'd0:  c = 7'h5f;  5'd1:  c = 7'h06;  5'd2:  c = 7'h3d;  5'd3:  c = 7'h2f;
      5'd4:  c = 7'h66;  5'd5:  c = 7'h6b;  5'd6:  c = 7'h7b;  5'd7:  c = 7'h0e;
      5'd8:  c = 7'h7f;  5'd9:  c = 7'h6f;  5'd10: c = 7'h7e;  5'd11: c = 7'h73;
      5'd12: c = 7'h59;  5'd13: c = 7'h37;  5'd14: c = 7'h79;  5'd15: c = 7'h78;
      5'd16: c = 7'h76;  5'd17: c = 7'h51;  5'd18: c = 7'h30;  5'd19: c = 7'h7c;
      5'd20: c = 7'h5e;  5'd21: c = 7'h20;  5'd22: c = 7'h08;  5'd23: c = 7'h01;
      5'd24: c = 7'h6c;  5'd25: c = 7'h33;  5'd26: c = 7'h57;  5'd27: c = 7'h31;
      5'd28: c = 7'h6d;  5'd29: c = 7'h3b;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Icon location: byte address
  function automatic addr_t icon_addr(input logic [2:0] icon);
    addr_t a;
    case (icon)
      3'd0:    a = addr_t'(2);
      3'd1:    a = addr_t'(0);
      3'd2:    a = addr_t'(0);
      3'd3:    a = addr_t'(7);
      3'd4:    a = addr_t'(11);
      3'd5:    a = addr_t'(16);
      default: a = addr_t'(0);
    endcase
    return a;
  endfunction

  // Icon location: bit mask
  function automatic byte_t icon_mask(input logic [2:0] icon);
    byte_t m;
    case (icon)
      3'd0:    m = 8'h01;
      3'd1:    m = 8'h10;
      3'd2:    m = 8'h80;
      3'd3:    m = 8'h80;
      3'd4:    m = 8'h10;
      3'd5:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> design/segment_lcd_frame_composer.sv
// ----------------------------------------------------------------------------
// segment_lcd_frame_composer : segment LCD image builder
// Keeps the display image in a small synchronous RAM, updates it by masked
// read-modify-write and streams it out on commit.
// ----------------------------------------------------------------------------
//
//  channel   | handshake        | word
//  ----------+------------------+-------------------------------------------
//  command   | start / busy     | in_cmd, in_position, in_symbol,
//            |                  | in_icon_index, in_display_off
//  frame out | out_strobe       | out_byte_index, out_byte_value, out_blank,
//            |                  | out_final_byte
//
// Clear store drops all valid bits at once. A digit write merges one byte
// for a single-byte position and two for a split position; an icon update
// merges one. Each costs one read and one write per touched byte on the
// RAM (one read port, one write port). Commit holds busy while it streams
// the 19 frame words, one word per cycle from the pipelined RAM read. Ignored
// commands leave busy low. Reset is synchronous, active low; it empties the
// image through per-entry valid bits, so no clearing pass is needed. Words
// are shown for exactly one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
module segment_lcd_frame_composer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  slfc_pkg::cmd_t    in_cmd,
  input  logic [3:0]        in_position,
  input  logic [4:0]        in_symbol,
  input  logic [2:0]        in_icon_index,
  input  logic              in_display_off,
  output logic              out_strobe,
  output slfc_pkg::idx_t    out_byte_index,
  output slfc_pkg::byte_t   out_byte_value,
  output logic              out_blank,
  output logic              out_final_byte
);
  import slfc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WR1  = 2'd1;  // merge first byte, read second
  localparam logic [1:0] S_WR2  = 2'd2;  // merge second byte
  localparam logic [1:0] S_SEND = 2'd3;  // stream frame

  logic [1:0] state_r, state_nxt;

  // image RAM, registered read
  byte_t mem [STORE_BYTES];
  byte_t mem_q_r;
  logic  rd_ok_r;
  logic [STORE_BYTES-1:0] valid_r;

  addr_t rd_addr;
  logic  mem_we;
  addr_t wr_addr;
  byte_t wr_data;
  byte_t old_byte;

  // pending update, captured at accept
  addr_t addr1_r, addr2_r;
  byte_t keep1_r, bits1_r, keep2_r, bits2_r;
  logic  has2_r;

  idx_t  cnt_r;
  logic  blank_r;

  // command decode
  logic       accept;
  logic       dec_rmw;
  logic       dec_two;
  addr_t      dec_addr1, dec_addr2;
  byte_t      dec_keep1, dec_bits1, dec_keep2, dec_bits2;
  logic [6:0] c1, c23;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    c1  = row1_code(in_symbol);
    c23 = row23_code(in_symbol);
    dec_rmw   = 1'b0;
    dec_two   = 1'b0;
    dec_addr1 = '0;
    dec_addr2 = '0;
    dec_keep1 = KEEP_ALL;
    dec_bits1 = '0;
    dec_keep2 = KEEP_ALL;
    dec_bits2 = '0;
    case (in_cmd)
      CMD_DIGIT: begin
        if (in_position <= 4'd1) begin
          dec_rmw   = 1'b1;
          dec_addr1 = addr_t'(4) - addr_t'(in_position);
          dec_keep1 = KEEP_DP;
          dec_bits1 = {1'b0, c1};
        end else if (in_position <= 4'd3) begin
          // row one, split nibbles: high nibble of byte 4-p, low bits of 3-p
          dec_rmw   = 1'b1;
          dec_two   = 1'b1;
          dec_addr1 = addr_t'(4) - addr_t'(in_position);
          dec_keep1 = KEEP_LO;
          dec_bits1 = {c1[3:0], 4'h0};
          dec_addr2 = addr_t'(3) - addr_t'(in_position);
          dec_keep2 = KEEP_HI5;
          dec_bits2 = {5'b0, c1[6:4]};
        end else if (in_position <= 4'd9) begin
          dec_rmw   = 1'b1;
          dec_addr1 = addr_t'(in_position) + addr_t'(1);
          dec_keep1 = KEEP_DP;
          dec_bits1 = {1'b0, c23};
        end else if (in_position <= 4'd14) begin
          dec_rmw   = 1'b1;
          dec_two   = 1'b1;
          dec_addr1 = addr_t'(in_position) + addr_t'(1);
          dec_keep1 = KEEP_HI5;
          dec_bits1 = {5'b0, c23[6:4]};
          dec_addr2 = addr_t'(in_position) + addr_t'(2);
          dec_keep2 = KEEP_LO;
          dec_bits2 = {c23[3:0], 4'h0};
        end
      end
      CMD_ICON_ON: begin
        if (in_icon_index < 3'(ICON_COUNT)) begin
          dec_rmw   = 1'b1;
          dec_addr1 = icon_addr(in_icon_index);
          dec_keep1 = KEEP_ALL;
          dec_bits1 = icon_mask(in_icon_index);
        end
      end
      CMD_ICON_OFF: begin
        if (in_icon_index < 3'(ICON_COUNT)) begin
          dec_rmw   = 1'b1;
          dec_addr1 = icon_addr(in_icon_index);
          dec_keep1 = ~icon_mask(in_icon_index);
          dec_bits1 = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM read address
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = (in_cmd == CMD_COMMIT) ? '0 : dec_addr1;
      S_WR1:   rd_addr = addr2_r;
      S_SEND:  rd_addr = addr_t'(cnt_r) + addr_t'(1);
      default: rd_addr = addr1_r;
    endcase
  end

  // entries never written since the last clear read as zero
  assign old_byte = rd_ok_r ? mem_q_r : '0;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = addr1_r;
    wr_data = (old_byte & keep1_r) | bits1_r;
    case (state_r)
      S_WR1: mem_we = 1'b1;
      S_WR2: begin
        mem_we  = 1'b1;
        wr_addr = addr2_r;
        wr_data = (old_byte & keep2_r) | bits2_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= valid_r[rd_addr];
      if (accept && in_cmd == CMD_CLEAR) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_COMMIT) begin
          state_nxt = S_SEND;
        end else if (accept && dec_rmw) begin
          state_nxt = S_WR1;
        end
      end
      S_WR1:   state_nxt = has2_r ? S_WR2 : S_IDLE;
      S_WR2:   state_nxt = S_IDLE;
      S_SEND:  state_nxt = (cnt_r == idx_t'(FRAME_LEN - 1)) ? S_IDLE : S_SEND;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SEND) begin
        cnt_r <= cnt_r + idx_t'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr1_r <= dec_addr1;
      addr2_r <= dec_addr2;
      keep1_r <= dec_keep1;
      bits1_r <= dec_bits1;
      keep2_r <= dec_keep2;
      bits2_r <= dec_bits2;
      has2_r  <= dec_two;
      blank_r <= in_display_off;
    end
  end

  // frame output, straight from the registered RAM read
  assign out_strobe     = (state_r == S_SEND);
  assign out_byte_index = cnt_r;
  assign out_byte_value = old_byte;
  assign out_blank      = blank_r;
  assign out_final_byte = (cnt_r == idx_t'(FRAME_LEN - 1));

endmodule

>>> bench/frame_image_checker.sv
// ----------------------------------------------------------------------------
// frame_image_checker : display image predictor and frame word scoreboard
// Keeps its own copy of the LCD image, updates it from every accepted command
// and checks each streamed frame word against the oldest word still due.
// ----------------------------------------------------------------------------
module frame_image_checker
  import slfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        in_cmd,
  input  logic [3:0]  in_position,
  input  logic [4:0]  in_symbol,
  input  logic [2:0]  in_icon_index,
  input  logic        in_display_off,
  input  logic        out_strobe,
  input  idx_t        out_byte_index,
  input  byte_t       out_byte_value,
  input  logic        out_blank,
  input  logic        out_final_byte,
  output int          fail_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // segment codes, symbol n at bits [8n +: 8]
  localparam logic [255:0] ROW1_SEGS =
    256'h00006d3b2c5e6c33_0801205737240e76_272f7c0f6e777b7f_516f6b72793d505f;
  localparam logic [255:0] ROW23_SEGS =
    256'h00003b6d3157336c_0108205e7c305176_78793759737e6f7f_0e7b6b662f3d065f;

  // icon n: byte address and bit, at bits [8n +: 8]
  localparam logic [47:0] ICON_AT   = {8'd16, 8'd11, 8'd7, 8'd0, 8'd0, 8'd2};
  localparam logic [47:0] ICON_MASK = {8'h01, 8'h10, 8'h80, 8'h80, 8'h10, 8'h01};

  typedef struct {
    idx_t  index;
    byte_t value;
    logic  blank;
    logic  last;
  } frame_word_t;

  byte_t       lcd_image [STORE_BYTES];
  frame_word_t frame_words_due [$];
  int          mismatches = 0;

  function automatic byte_t seg_code(input logic row_one, input logic [4:0] sym);
    return row_one ? ROW1_SEGS[sym * 8 +: 8] : ROW23_SEGS[sym * 8 +: 8];
  endfunction

  task automatic merge_byte(input int at, input byte_t keep, input byte_t bits);
    if (at < STORE_BYTES) lcd_image[at] = (lcd_image[at] & keep) | bits;
  endtask

  task automatic compose_command(input cmd_t c, input logic [3:0] p,
                                 input logic [4:0] s, input logic [2:0] ic,
                                 input logic off);
    byte_t       code;
    int          at;
    byte_t       mask;
    frame_word_t w;
    code = seg_code(p <= 3, s);
    at   = int'(ICON_AT[ic * 8 +: 8]);
    mask = ICON_MASK[ic * 8 +: 8];
    case (c)
      CMD_CLEAR: foreach (lcd_image[i]) lcd_image[i] = '0;
      CMD_DIGIT: begin
        if (p <= 1) begin
          merge_byte(4 - p, KEEP_DP, code);
        end else if (p <= 3) begin
          // row one split digit: low nibble up high, bits 6..4 into next byte down
          merge_byte(4 - p, KEEP_LO, code << 4);
          merge_byte(3 - p, KEEP_HI5, code >> 4);
        end else if (p <= 9) begin
          merge_byte(p + 1, KEEP_DP, code);
        end else if (p <= 14) begin
          merge_byte(p + 1, KEEP_HI5, code >> 4);
          merge_byte(p + 2, KEEP_LO, code << 4);
        end
      end
      CMD_ICON_ON:  if (ic < ICON_COUNT) lcd_image[at] = lcd_image[at] | mask;
      CMD_ICON_OFF: if (ic < ICON_COUNT) lcd_image[at] = lcd_image[at] & ~mask;
      CMD_COMMIT: begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          w.index = idx_t'(i);
          w.value = lcd_image[i];
          w.blank = off;
          w.last  = (i == FRAME_LEN - 1);
          frame_words_due.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int at, input int due,
                               input int got);
    if (due != got) begin
      mismatches++;
      $display("%0t: word %0d %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, at, name, due, got);
    end
  endtask

  always @(posedge clk) begin : watch
    frame_word_t due;
    if (!rst_n) begin
      foreach (lcd_image[i]) lcd_image[i] = '0;
      frame_words_due.delete();
    end else begin
      if (out_strobe) begin
        if (frame_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual index %0d value 0x%0h",
                   $time, out_byte_index, out_byte_value);
        end else begin
          due = frame_words_due.pop_front();
          compare_field("byte_index", int'(due.index), int'(due.index),
                        int'(out_byte_index));
          compare_field("byte_value", int'(due.index), int'(due.value),
                        int'(out_byte_value));
          compare_field("blank", int'(due.index), int'(due.blank), int'(out_blank));
          compare_field("final_byte", int'(due.index), int'(due.last),
                        int'(out_final_byte));
        end
      end
      if (start && !busy)
        compose_command(in_cmd, in_position, in_symbol, in_icon_index, in_display_off);
    end
    words_pending <= frame_words_due.size();
    fail_count    <= mismatches;
  end

endmodule

>>> bench/tb_segment_lcd_frame_composer.sv
// ----------------------------------------------------------------------------
// tb_segment_lcd_frame_composer : testbench for the segment LCD frame composer
// Drives a directed command list, then a few hundred random commands with
// random gaps outside a back-to-back middle run; the checker beside the block predicts every frame word.
// ----------------------------------------------------------------------------
module tb_segment_lcd_frame_composer;
  timeunit 1ns;
  timeprecision 1ps;
  import slfc_pkg::*;

  // cmd codes the block has no use for
  localparam cmd_t CMD_SPARE_LO = 3'd5;
  localparam cmd_t CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_WORDS = 325;
  // longest correct quiet spell is a run of random gap cycles plus a split write
  localparam int QUIET_LIMIT  = 500;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  cmd_t        in_cmd         = CMD_CLEAR;
  logic [3:0]  in_position    = '0;
  logic [4:0]  in_symbol      = '0;
  logic [2:0]  in_icon_index  = '0;
  logic        in_display_off = 1'b0;
  logic        busy;
  logic        out_strobe;
  idx_t        out_byte_index;
  byte_t       out_byte_value;
  logic        out_blank;
  logic        out_final_byte;

  int          fail_count;
  int          words_pending;
  int          quiet_cycles = 0;
  bit          idle_gaps = 1'b1;

  always #5 clk = ~clk;

  segment_lcd_frame_composer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_symbol      (in_symbol),
    .in_icon_index  (in_icon_index),
    .in_display_off (in_display_off),
    .out_strobe     (out_strobe),
    .out_byte_index (out_byte_index),
    .out_byte_value (out_byte_value),
    .out_blank      (out_blank),
    .out_final_byte (out_final_byte)
  );

  frame_image_checker image_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_symbol      (in_symbol),
    .in_icon_index  (in_icon_index),
    .in_display_off (in_display_off),
    .out_strobe     (out_strobe),
    .out_byte_index (out_byte_index),
    .out_byte_value (out_byte_value),
    .out_blank      (out_blank),
    .out_final_byte (out_final_byte),
    .fail_count     (fail_count),
    .words_pending  (words_pending)
  );

  // Watchdog: any accepted command or streamed word resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One command word; random gap cycles ahead of it while idle_gaps is set.
  // Returns at the edge that accepts the word, with start still high so that
  // back-to-back words need only one assignment per edge.
  task automatic send_word(input cmd_t c, input logic [3:0] p, input logic [4:0] s,
                           input logic [2:0] ic, input logic off);
    while (idle_gaps && ($urandom_range(99) < 15)) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= c;
    in_position    <= p;
    in_symbol      <= s;
    in_icon_index  <= ic;
    in_display_off <= off;
    do @(posedge clk); while (busy);
  endtask

  // Hold the command side off until the checker has nothing left due.
  // The first edge lets a just-accepted commit show up in the count.
  task automatic drain_frame();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin
    int   sent;
    int   pick;
    cmd_t c;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // blank image straight out of reset
    send_word(CMD_COMMIT, 4'($urandom), 5'($urandom), 3'($urandom), 1'b0);
    // row one: plain digits, then the two split ones; the eights light all segments
    send_word(CMD_DIGIT, 4'd0, 5'd8, 3'($urandom), 1'($urandom));
    send_word(CMD_DIGIT, 4'd1, 5'd31, 3'($urandom), 1'($urandom));  // 31 reads as blank
    send_word(CMD_DIGIT, 4'd2, 5'd8, 3'($urandom), 1'($urandom));
    send_word(CMD_DIGIT, 4'd3, 5'd29, 3'($urandom), 1'($urandom));
    // rows two and three: first and last whole-byte digit, split digits
    send_word(CMD_DIGIT, 4'd4, 5'd0, 3'($urandom), 1'($urandom));
    send_word(CMD_DIGIT, 4'd9, 5'd30, 3'($urandom), 1'($urandom));
    send_word(CMD_DIGIT, 4'd10, 5'd8, 3'($urandom), 1'($urandom));
    send_word(CMD_DIGIT, 4'd14, 5'd8, 3'($urandom), 1'($urandom));
    // position out of range must leave the image alone
    send_word(CMD_DIGIT, 4'd15, 5'd8, 3'($urandom), 1'($urandom));
    // every icon on, including the two that do nothing
    for (int i = 0; i < 8; i++)
      send_word(CMD_ICON_ON, 4'($urandom), 5'($urandom), 3'(i), 1'($urandom));
    send_word(CMD_ICON_OFF, 4'($urandom), 5'($urandom), 3'd3, 1'($urandom));
    send_word(CMD_ICON_OFF, 4'($urandom), 5'($urandom), 3'd7, 1'($urandom));
    // unused cmd codes are dropped
    send_word(CMD_SPARE_LO, 4'($urandom), 5'($urandom), 3'($urandom), 1'($urandom));
    send_word(CMD_SPARE_HI, 4'($urandom), 5'($urandom), 3'($urandom), 1'($urandom));
    send_word(CMD_COMMIT, 4'($urandom), 5'($urandom), 3'($urandom), 1'b1);
    drain_frame();
    send_word(CMD_CLEAR, 4'($urandom), 5'($urandom), 3'($urandom), 1'($urandom));
    send_word(CMD_COMMIT, 4'd15, 5'd31, 3'd7, 1'b0);
    drain_frame();

    // ---- random part ----
    // Mostly digit and icon updates with a commit every so often; the bench
    // sends a long run of back-to-back words in the middle.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      idle_gaps = !((sent >= 120) && (sent < 200));
      pick = $urandom_range(99);
      if (pick < 45)      c = CMD_DIGIT;
      else if (pick < 62) c = CMD_ICON_ON;
      else if (pick < 72) c = CMD_ICON_OFF;
      else if (pick < 84) c = CMD_COMMIT;
      else if (pick < 88) c = CMD_CLEAR;
      else                c = cmd_t'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      send_word(c, 4'($urandom_range(15)), 5'($urandom_range(31)),
                3'($urandom_range(7)), 1'($urandom_range(1)));
      sent++;
      // now and then let a whole frame drain before the next command
      if ((c == CMD_COMMIT) && ($urandom_range(3) == 0)) drain_frame();
    end

    // ---- wind down ----
    drain_frame();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
